// ===== hdl/jsp_pkg.sv =====
// Shared types, register offsets and pad protocol constants for the
// joypad serial port. No dependencies.
package jsp_pkg;

  localparam int ACK_EXTRA_DEF = 76;

  localparam int DELAY_W = 25;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [2:0] {
    KIND_READ    = 3'd0,
    KIND_WRITE   = 3'd1,
    KIND_PRESS   = 3'd2,
    KIND_RELEASE = 3'd3,
    KIND_DELIVER = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    OFF_DATA = 4'd0,
    OFF_STAT = 4'd4,
    OFF_MODE = 4'd8,
    OFF_CTRL = 4'd10,
    OFF_BAUD = 4'd14
  } reg_off_t;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_PAD  = 2'd1,
    TGT_CARD = 2'd2
  } tgt_t;

  typedef enum logic [2:0] {
    STEP_ADDR = 3'd0,
    STEP_CMD  = 3'd1,
    STEP_ID   = 3'd2,
    STEP_LO   = 3'd3,
    STEP_HI   = 3'd4
  } step_t;

  localparam logic [8:0] MODE_MASK = 9'h13F;
  localparam logic [7:0] ADDR_PAD  = 8'h01;
  localparam logic [7:0] ADDR_CARD = 8'h81;
  localparam logic [7:0] CMD_READ  = 8'h42;
  localparam logic [7:0] ID_LO     = 8'h41;
  localparam logic [7:0] ID_HI     = 8'h5A;
  localparam logic [7:0] IDLE_BYTE = 8'hFF;

  localparam int CTRL_SEL     = 1;
  localparam int CTRL_IRQ_ACK = 4;
  localparam int CTRL_RESET   = 6;
  localparam int CTRL_IRQ_EN  = 12;
  localparam int CTRL_PORT2   = 13;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  reg_offset;
    logic [15:0] write_data;
    logic [3:0]  button_index;
  } item_t;

  typedef struct packed {
    logic               irq_raise;
    logic [DELAY_W-1:0] ack_delay_cycles;
    logic               pad_acknowledge;
    logic [15:0]        read_data;
  } result_t;

endpackage

// ===== hdl/jsp_regs.sv =====
// Register file, pad exchange sequencer and acknowledge delay of the
// joypad serial port. Depends on jsp_pkg.
module jsp_regs #(
  parameter int ACK_EXTRA_CYCLES = jsp_pkg::ACK_EXTRA_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  jsp_pkg::item_t   item,
  output jsp_pkg::result_t res
);

  logic [15:0]     btn_r, btn_nxt;
  logic [15:0]     ctrl_r, ctrl_nxt;
  logic [8:0]      mode_r, mode_nxt;
  logic [15:0]     baud_r, baud_nxt;
  logic [7:0]      rx_byte_r, rx_byte_nxt;
  logic            rx_full_r, rx_full_nxt;
  logic            irq_r, irq_nxt;
  jsp_pkg::tgt_t   tgt_r, tgt_nxt;
  jsp_pkg::step_t  step_r, step_nxt;

  jsp_pkg::tgt_t   pad_tgt_nxt;
  jsp_pkg::step_t  pad_step_nxt;
  logic [7:0]      pad_ans;
  logic            pad_ack;
  logic [7:0]      tx;
  logic [21:0]     period;
  logic [21:0]     period_min;

  assign tx = item.write_data[7:0];

  // Pad exchange: next target and step for a data write
  always_comb begin
    pad_tgt_nxt  = tgt_r;
    pad_step_nxt = step_r;
    case (tgt_r)
      jsp_pkg::TGT_NONE: begin
        if (tx == jsp_pkg::ADDR_PAD && !ctrl_r[jsp_pkg::CTRL_PORT2]) begin
          pad_tgt_nxt  = jsp_pkg::TGT_PAD;
          pad_step_nxt = jsp_pkg::STEP_CMD;
        end else if (tx == jsp_pkg::ADDR_CARD) begin
          pad_tgt_nxt = jsp_pkg::TGT_CARD;
        end
      end
      jsp_pkg::TGT_PAD: begin
        case (step_r)
          jsp_pkg::STEP_CMD: begin
            if (tx == jsp_pkg::CMD_READ) begin
              pad_step_nxt = jsp_pkg::STEP_ID;
            end else begin
              pad_tgt_nxt  = jsp_pkg::TGT_NONE;
              pad_step_nxt = jsp_pkg::STEP_ADDR;
            end
          end
          jsp_pkg::STEP_ID: pad_step_nxt = jsp_pkg::STEP_LO;
          jsp_pkg::STEP_LO: pad_step_nxt = jsp_pkg::STEP_HI;
          default: begin
            pad_tgt_nxt  = jsp_pkg::TGT_NONE;
            pad_step_nxt = jsp_pkg::STEP_ADDR;
          end
        endcase
      end
      default: ;
    endcase
  end

  // Pad exchange: answer byte and acknowledge
  always_comb begin
    pad_ans = jsp_pkg::IDLE_BYTE;
    pad_ack = 1'b0;
    case (tgt_r)
      jsp_pkg::TGT_NONE: begin
        pad_ack = (tx == jsp_pkg::ADDR_PAD) && !ctrl_r[jsp_pkg::CTRL_PORT2];
      end
      jsp_pkg::TGT_PAD: begin
        case (step_r)
          jsp_pkg::STEP_CMD: begin
            if (tx == jsp_pkg::CMD_READ) begin
              pad_ans = jsp_pkg::ID_LO;
              pad_ack = 1'b1;
            end
          end
          jsp_pkg::STEP_ID: begin
            pad_ans = jsp_pkg::ID_HI;
            pad_ack = 1'b1;
          end
          jsp_pkg::STEP_LO: begin
            pad_ans = btn_r[7:0];
            pad_ack = 1'b1;
          end
          default: pad_ans = btn_r[15:8];
        endcase
      end
      default: ;
    endcase
  end

  // Register update, read mux and acknowledge delay
  always_comb begin
    btn_nxt     = btn_r;
    ctrl_nxt    = ctrl_r;
    mode_nxt    = mode_r;
    baud_nxt    = baud_r;
    rx_byte_nxt = rx_byte_r;
    rx_full_nxt = rx_full_r;
    irq_nxt     = irq_r;
    tgt_nxt     = tgt_r;
    step_nxt    = step_r;
    res.read_data       = 16'h0000;
    res.pad_acknowledge = 1'b0;
    res.irq_raise       = 1'b0;
    case (item.kind)
      jsp_pkg::KIND_READ: begin
        case (item.reg_offset)
          jsp_pkg::OFF_DATA: begin
            res.read_data = rx_full_r ? {8'h00, rx_byte_r} : {8'h00, jsp_pkg::IDLE_BYTE};
            rx_full_nxt   = 1'b0;
          end
          jsp_pkg::OFF_STAT: res.read_data = {6'b0, irq_r, 6'b0, 1'b1, rx_full_r, 1'b1};
          jsp_pkg::OFF_MODE: res.read_data = {7'b0, mode_r};
          jsp_pkg::OFF_CTRL: res.read_data = ctrl_r;
          jsp_pkg::OFF_BAUD: res.read_data = baud_r;
          default: ;
        endcase
      end
      jsp_pkg::KIND_WRITE: begin
        case (item.reg_offset)
          jsp_pkg::OFF_DATA: begin
            rx_byte_nxt         = pad_ans;
            rx_full_nxt         = 1'b1;
            tgt_nxt             = pad_tgt_nxt;
            step_nxt            = pad_step_nxt;
            res.pad_acknowledge = pad_ack;
          end
          jsp_pkg::OFF_MODE: mode_nxt = item.write_data[8:0] & jsp_pkg::MODE_MASK;
          jsp_pkg::OFF_CTRL: begin
            ctrl_nxt = item.write_data;
            ctrl_nxt[jsp_pkg::CTRL_IRQ_ACK] = 1'b0;
            ctrl_nxt[jsp_pkg::CTRL_RESET]   = 1'b0;
            if (item.write_data[jsp_pkg::CTRL_IRQ_ACK]) begin
              irq_nxt = 1'b0;
            end
            if (item.write_data[jsp_pkg::CTRL_RESET]) begin
              btn_nxt     = 16'hFFFF;
              ctrl_nxt    = 16'h0000;
              mode_nxt    = 9'h000;
              baud_nxt    = 16'h0000;
              rx_byte_nxt = 8'h00;
              rx_full_nxt = 1'b0;
              irq_nxt     = 1'b0;
            end
            // deselect (or soft reset) drops the exchange
            if (!item.write_data[jsp_pkg::CTRL_SEL] || item.write_data[jsp_pkg::CTRL_RESET]) begin
              tgt_nxt  = jsp_pkg::TGT_NONE;
              step_nxt = jsp_pkg::STEP_ADDR;
            end
          end
          jsp_pkg::OFF_BAUD: baud_nxt = item.write_data;
          default: ;
        endcase
      end
      jsp_pkg::KIND_PRESS:   btn_nxt[item.button_index] = 1'b0;
      jsp_pkg::KIND_RELEASE: btn_nxt[item.button_index] = 1'b1;
      jsp_pkg::KIND_DELIVER: begin
        irq_nxt       = 1'b1;
        res.irq_raise = ctrl_r[jsp_pkg::CTRL_IRQ_EN];
      end
      default: ;
    endcase

    // Acknowledge delay from the updated baud and mode: factor 1, 1, 16, 64
    case (mode_nxt[1:0])
      2'd2:    period = {2'b00, baud_nxt, 4'b0000};
      2'd3:    period = {baud_nxt, 6'b000000};
      default: period = {6'b000000, baud_nxt};
    endcase
    period_min = (period == 22'd0) ? 22'd1 : period;
    res.ack_delay_cycles = {period_min, 3'b000}
                         + jsp_pkg::DELAY_W'(ACK_EXTRA_CYCLES);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btn_r     <= 16'hFFFF;
      ctrl_r    <= 16'h0000;
      mode_r    <= 9'h000;
      baud_r    <= 16'h0000;
      rx_byte_r <= 8'h00;
      rx_full_r <= 1'b0;
      irq_r     <= 1'b0;
      tgt_r     <= jsp_pkg::TGT_NONE;
      step_r    <= jsp_pkg::STEP_ADDR;
    end else if (en) begin
      btn_r     <= btn_nxt;
      ctrl_r    <= ctrl_nxt;
      mode_r    <= mode_nxt;
      baud_r    <= baud_nxt;
      rx_byte_r <= rx_byte_nxt;
      rx_full_r <= rx_full_nxt;
      irq_r     <= irq_nxt;
      tgt_r     <= tgt_nxt;
      step_r    <= step_nxt;
    end
  end

`ifndef SYNTHESIS
  a_step_follows_target: assert property (@(posedge clk) disable iff (!rst_n)
    (tgt_r == jsp_pkg::TGT_PAD) == (step_r != jsp_pkg::STEP_ADDR))
    else $error("exchange step out of line with target");

  a_soft_reset: assert property (@(posedge clk) disable iff (!rst_n)
    en && item.kind == jsp_pkg::KIND_WRITE && item.reg_offset == jsp_pkg::OFF_CTRL
      && item.write_data[jsp_pkg::CTRL_RESET]
    |=> btn_r == 16'hFFFF && ctrl_r == 16'h0000 && tgt_r == jsp_pkg::TGT_NONE)
    else $error("soft reset did not restore state");

  a_data_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    en && item.kind == jsp_pkg::KIND_READ && item.reg_offset == jsp_pkg::OFF_DATA
    |=> !rx_full_r)
    else $error("data read left receive flag set");
`endif

endmodule

// ===== hdl/joypad_serial_port_unit.sv =====
// Joypad serial port: streaming wrapper with input and result registers
// around the register block. Depends on jsp_pkg and jsp_regs.
//
// Each accepted word passes the input register and then the result register.
// Throughput: one word per cycle while out_tready is high; the register
// update and read mux sit between the input and result registers.
// Reset: synchronous, active low; both stages empty, pad registers cleared,
// every button released.
module joypad_serial_port_unit #(
  parameter int ACK_EXTRA_CYCLES = jsp_pkg::ACK_EXTRA_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [3:0] reg_offset, [19:4] write_data, [23:20] button_index
  input  logic [jsp_pkg::IN_DATA_W-1:0]  in_tdata,
  // [2:0] kind
  input  logic [2:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] read_data, [16] pad_acknowledge, [41:17] ack_delay_cycles,
  // [42] irq_raise, [47:43] zero
  output logic [jsp_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic             in_v_r;
  jsp_pkg::item_t   item_r;
  logic             out_v_r;
  jsp_pkg::result_t res_r;
  jsp_pkg::result_t res;
  logic             in_fire;
  logic             adv;

  // Advance the held word into the result register when that slot frees up
  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_fire) begin
        in_v_r <= 1'b1;
      end else if (adv) begin
        in_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset, load on handshake
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.kind         <= jsp_pkg::kind_t'(in_tuser);
      item_r.reg_offset   <= in_tdata[3:0];
      item_r.write_data   <= in_tdata[19:4];
      item_r.button_index <= in_tdata[23:20];
    end
    if (adv) begin
      res_r <= res;
    end
  end

  jsp_regs #(
    .ACK_EXTRA_CYCLES(ACK_EXTRA_CYCLES)
  ) u_regs (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (adv),
    .item (item_r),
    .res  (res)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'b00000, res_r.irq_raise, res_r.ack_delay_cycles,
                       res_r.pad_acknowledge, res_r.read_data};

`ifndef SYNTHESIS
  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_v_r && out_v_r)
    else $error("input stalled with a free stage");

  a_delay_low_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> res_r.ack_delay_cycles[2:0] == 3'(ACK_EXTRA_CYCLES))
    else $error("acknowledge delay not a multiple of eight plus offset");

  a_ack_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.pad_acknowledge |-> res_r.read_data == 16'h0000 && !res_r.irq_raise)
    else $error("acknowledged write carries read data or interrupt");
`endif

endmodule
